// ----- rtl/core/audio_clip_or_tanh_shaper_top_defines.svh -----
// ---------------------------------------------------------------------------
// Audio clip / tanh shaper: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef AUDIO_CLIP_OR_TANH_SHAPER_TOP_DEFINES_SVH
`define AUDIO_CLIP_OR_TANH_SHAPER_TOP_DEFINES_SVH

// same-cycle implication
`define ACTS_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("shaper assertion failed: same-cycle implication");

// next-cycle implication
`define ACTS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("shaper assertion failed: next-cycle implication");

`endif

// ----- rtl/core/acts_pkg.sv -----
// ---------------------------------------------------------------------------
// acts_pkg
// Widths, register indexes, sideband type and the tanh segment table.
// ---------------------------------------------------------------------------
package acts_pkg;

   // sample format: signed Q3.FRAC_BITS
   localparam int SAMPLE_WIDTH  = 24;
   localparam int TANH_SEGMENTS = 64;
   localparam int FRAC_BITS     = SAMPLE_WIDTH - 4;

   // derived widths
   localparam int PROD_W = 2 * SAMPLE_WIDTH;                // full product
   localparam int IDX_W  = $clog2(TANH_SEGMENTS + 1);       // segment index
   localparam int R_W    = SAMPLE_WIDTH - 1;                // segment fraction
   localparam int MAG_W  = R_W + IDX_W;                     // |y| * segments
   localparam int ROM_W  = FRAC_BITS + 1;                   // table entry, Q0.F
   localparam int T_W    = ROM_W + 1;                       // signed tanh value
   localparam int DR_W   = ROM_W + R_W;                     // slope * fraction

   // table build constants
   localparam int EXP_BITS  = 30;
   localparam int SER_BITS  = 58;
   localparam int SER_TERMS = 40;

   // saturation limits
   localparam longint SAMPLE_MAX_L = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
   localparam longint SAMPLE_MIN_L = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHAPE_MODE = 2'd0,
      CSR_PARAM_A    = 2'd1,
      CSR_PARAM_B    = 2'd2
   } csr_index_type;

   // per-request sideband carried down the pipe
   typedef struct packed {
      logic                    mode;
      logic                    last;
      logic                    sat;
      logic [SAMPLE_WIDTH-1:0] clip;
   } side_type;

   typedef logic [0:TANH_SEGMENTS][ROM_W-1:0] rom_type;

   // unsigned quotient by shift and subtract, used while building the table
   function automatic longint unsigned udiv_u64(longint unsigned num,
                                                longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(8k/N) in Q0.F, built with integer steps from a series for e^(-16/N)
   function automatic rom_type build_tanh_rom();
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      rom_type         rom;
      term = 64'd1 << SER_BITS;
      sum  = term;
      for (int n = 1; n <= SER_TERMS; n++) begin
         term = udiv_u64(term * 64'd16, 64'(TANH_SEGMENTS) * 64'(n));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      q = (sum + (64'd1 << (SER_BITS - EXP_BITS - 1))) >> (SER_BITS - EXP_BITS);
      e = 64'd1 << EXP_BITS;
      for (int k = 0; k <= TANH_SEGMENTS; k++) begin
         if (k > 0) begin
            e = (e * q + (64'd1 << (EXP_BITS - 1))) >> EXP_BITS;
         end
         num    = ((64'd1 << EXP_BITS) - e) << (FRAC_BITS + 1);
         den    = (64'd1 << EXP_BITS) + e;
         rom[k] = ROM_W'(udiv_u64(num + den, 64'd2 * den));
      end
      return rom;
   endfunction

   localparam rom_type TANH_ROM = build_tanh_rom();

endpackage

// ----- rtl/core/acts_round_sat.sv -----
// ---------------------------------------------------------------------------
// acts_round_sat
// Rounds a Q7.2F product to Q3.F (half up) and saturates to sample range.
// ---------------------------------------------------------------------------
module acts_round_sat (
   input  logic signed [acts_pkg::PROD_W-1:0]       prod_in,
   output logic signed [acts_pkg::SAMPLE_WIDTH-1:0] sample_out,
   output logic                                     sat_out
);

   localparam logic signed [acts_pkg::PROD_W-1:0] HALF_LSB =
      acts_pkg::PROD_W'(64'sd1 <<< (acts_pkg::FRAC_BITS - 1));
   localparam logic signed [acts_pkg::PROD_W-1:0] WIDE_MAX =
      acts_pkg::PROD_W'(acts_pkg::SAMPLE_MAX_L);
   localparam logic signed [acts_pkg::PROD_W-1:0] WIDE_MIN =
      acts_pkg::PROD_W'(acts_pkg::SAMPLE_MIN_L);

   logic signed [acts_pkg::PROD_W-1:0] rounded;

   // round half up, then clamp
   assign rounded = (prod_in + HALF_LSB) >>> acts_pkg::FRAC_BITS;

   always_comb begin
      if (rounded > WIDE_MAX) begin
         sample_out = acts_pkg::SAMPLE_WIDTH'(WIDE_MAX);
         sat_out    = 1'b1;
      end else if (rounded < WIDE_MIN) begin
         sample_out = acts_pkg::SAMPLE_WIDTH'(WIDE_MIN);
         sat_out    = 1'b1;
      end else begin
         sample_out = rounded[acts_pkg::SAMPLE_WIDTH-1:0];
         sat_out    = 1'b0;
      end
   end

endmodule

// ----- rtl/core/audio_clip_or_tanh_shaper_top.sv -----
// ---------------------------------------------------------------------------
// audio_clip_or_tanh_shaper_top
// Per-sample waveshaper: hard clip to [a, b], or a * tanh(b * x) with a
// piecewise-linear tanh table. Seven register stages, sideband alongside.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_stall, sample_in, last_in | in
//  rsp     | rsp_valid/rsp_stall, sample_out,        | out
//          | saturated, last_out                     |
//  csr     | csr_write_en, csr_index, csr_wdata      | in
//
// One request per cycle unless rsp_stall backs up the pipe; rsp_valid rises at stage 7.
// The two 24x24-class multipliers and the table interpolation multiplier
// each sit alone between registers, which sets the stage count.
// Synchronous reset clears valid bits and config regs (mode 0, a=-1, b=+1).
// A stall on rsp only holds occupied stages; empty stages keep filling.
// ---------------------------------------------------------------------------
`include "audio_clip_or_tanh_shaper_top_defines.svh"

module audio_clip_or_tanh_shaper_top (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [acts_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                                     req_last_in,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [acts_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                                     rsp_saturated,
   output logic                                     rsp_last_out,
   // configuration
   input  logic                                     csr_write_en,
   input  acts_pkg::csr_index_type                  csr_index,
   input  logic [acts_pkg::SAMPLE_WIDTH-1:0]        csr_wdata
);

   localparam int NUM_STAGES = 7;
   localparam int SW         = acts_pkg::SAMPLE_WIDTH;

   localparam logic signed [SW-1:0] ONE_Q =
      SW'(64'sd1 <<< acts_pkg::FRAC_BITS);
   localparam logic [acts_pkg::DR_W:0] HALF_R =
      (acts_pkg::DR_W + 1)'(64'd1 << (acts_pkg::R_W - 1));
   localparam logic [acts_pkg::IDX_W-1:0] LAST_IDX =
      acts_pkg::IDX_W'(acts_pkg::TANH_SEGMENTS);

   // configuration registers
   logic                 mode_ff;
   logic signed [SW-1:0] param_a_ff;
   logic signed [SW-1:0] param_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         param_a_ff <= -ONE_Q;
         param_b_ff <= ONE_Q;
      end else if (csr_write_en) begin
         unique case (csr_index)
            acts_pkg::CSR_SHAPE_MODE: mode_ff    <= csr_wdata[0];
            acts_pkg::CSR_PARAM_A:    param_a_ff <= csr_wdata;
            acts_pkg::CSR_PARAM_B:    param_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control: a stage moves when empty or its successor moves
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int s = NUM_STAGES - 1; s >= 1; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-1:1], req_valid};
   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 1; s <= NUM_STAGES; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // stage 1: input gain product and clip result
   logic signed [acts_pkg::PROD_W-1:0] s1_prod_in, s1_prod_ff;
   logic signed [SW-1:0]               s1_clip;
   acts_pkg::side_type                 s1_side_in, s1_side_ff;

   always_comb begin
      // lower limit is tested first
      if (req_sample_in < param_a_ff) begin
         s1_clip = param_a_ff;
      end else if (req_sample_in > param_b_ff) begin
         s1_clip = param_b_ff;
      end else begin
         s1_clip = req_sample_in;
      end
      s1_prod_in      = param_b_ff * req_sample_in;
      s1_side_in.mode = mode_ff;
      s1_side_in.last = req_last_in;
      s1_side_in.sat  = 1'b0;
      s1_side_in.clip = s1_clip;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_prod_ff <= s1_prod_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // stage 2: round and saturate, split |y| into segment and fraction
   logic signed [SW-1:0]             s2_y;
   logic                             s2_sat;
   logic [SW-1:0]                    s2_mag;
   logic [acts_pkg::MAG_W-1:0]       s2_scaled;
   logic                             s2_neg_in, s2_neg_ff;
   logic [acts_pkg::IDX_W-1:0]       s2_idx_ff;
   logic [acts_pkg::R_W-1:0]         s2_r_ff;
   acts_pkg::side_type               s2_side_in, s2_side_ff;

   acts_round_sat u_sat_in (
      .prod_in    (s1_prod_ff),
      .sample_out (s2_y),
      .sat_out    (s2_sat)
   );

   always_comb begin
      s2_neg_in      = s2_y[SW-1];
      s2_mag         = s2_neg_in ? SW'(-s2_y) : SW'(s2_y);
      s2_scaled      = acts_pkg::MAG_W'(s2_mag) *
                       acts_pkg::MAG_W'(acts_pkg::TANH_SEGMENTS);
      s2_side_in     = s1_side_ff;
      s2_side_in.sat = s2_sat;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_neg_ff  <= s2_neg_in;
         s2_idx_ff  <= s2_scaled[acts_pkg::MAG_W-1:acts_pkg::R_W];
         s2_r_ff    <= s2_scaled[acts_pkg::R_W-1:0];
         s2_side_ff <= s2_side_in;
      end
   end

   // stage 3: table lookup, base and slope of the segment
   logic [acts_pkg::IDX_W-1:0] s3_hi_idx;
   logic [acts_pkg::ROM_W-1:0] s3_lo_in, s3_lo_ff;
   logic [acts_pkg::ROM_W-1:0] s3_d_in, s3_d_ff;
   logic [acts_pkg::R_W-1:0]   s3_r_ff;
   logic                       s3_neg_ff;
   acts_pkg::side_type         s3_side_ff;

   always_comb begin
      // past the last segment: zero slope on the end point
      s3_hi_idx = (s2_idx_ff >= LAST_IDX) ? LAST_IDX : s2_idx_ff + 1'b1;
      s3_lo_in  = acts_pkg::TANH_ROM[s2_idx_ff];
      s3_d_in   = acts_pkg::TANH_ROM[s3_hi_idx] - s3_lo_in;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_lo_ff   <= s3_lo_in;
         s3_d_ff    <= s3_d_in;
         s3_r_ff    <= s2_r_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // stage 4: slope times fraction
   logic [acts_pkg::DR_W-1:0]  s4_dr_in, s4_dr_ff;
   logic [acts_pkg::ROM_W-1:0] s4_lo_ff;
   logic                       s4_neg_ff;
   acts_pkg::side_type         s4_side_ff;

   assign s4_dr_in = acts_pkg::DR_W'(s3_d_ff) * acts_pkg::DR_W'(s3_r_ff);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_dr_ff   <= s4_dr_in;
         s4_lo_ff   <= s3_lo_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // stage 5: rounded interpolation and sign
   logic [acts_pkg::DR_W:0]           s5_sum;
   logic [acts_pkg::ROM_W-1:0]        s5_mag;
   logic signed [acts_pkg::T_W-1:0]   s5_pos;
   logic signed [acts_pkg::T_W-1:0]   s5_t_in, s5_t_ff;
   acts_pkg::side_type                s5_side_ff;

   always_comb begin
      s5_sum  = (acts_pkg::DR_W + 1)'(s4_dr_ff) + HALF_R;
      s5_mag  = s4_lo_ff + s5_sum[acts_pkg::R_W +: acts_pkg::ROM_W];
      s5_pos  = {1'b0, s5_mag};
      s5_t_in = s4_neg_ff ? -s5_pos : s5_pos;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_t_ff    <= s5_t_in;
         s5_side_ff <= s4_side_ff;
      end
   end

   // stage 6: output gain product
   logic signed [acts_pkg::PROD_W-1:0] s6_prod_in, s6_prod_ff;
   acts_pkg::side_type                 s6_side_ff;

   assign s6_prod_in = param_a_ff * s5_t_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_prod_ff <= s6_prod_in;
         s6_side_ff <= s5_side_ff;
      end
   end

   // stage 7: final round/saturate and mode select into the output register
   logic signed [SW-1:0] s7_y;
   logic                 s7_sat;
   logic signed [SW-1:0] rsp_sample_in, rsp_sample_ff;
   logic                 rsp_sat_in, rsp_sat_ff;
   logic                 rsp_last_ff;

   acts_round_sat u_sat_out (
      .prod_in    (s6_prod_ff),
      .sample_out (s7_y),
      .sat_out    (s7_sat)
   );

   always_comb begin
      if (s6_side_ff.mode) begin
         rsp_sample_in = s7_y;
         rsp_sat_in    = s6_side_ff.sat || s7_sat;
      end else begin
         rsp_sample_in = s6_side_ff.clip;
         rsp_sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_sat_ff    <= rsp_sat_in;
         rsp_last_ff   <= s6_side_ff.last;
      end
   end

   assign rsp_valid      = valid_ff[NUM_STAGES];
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_last_out   = rsp_last_ff;

   // checks
   `ACTS_ASSERT_IMPLY(a_full_pipe_stalls_req, (&valid_ff) && rsp_stall, req_stall)
   `ACTS_ASSERT_NEXT(a_held_stage_kept, valid_ff[NUM_STAGES-1] && !adv[NUM_STAGES], valid_ff[NUM_STAGES-1])
   `ACTS_ASSERT_IMPLY(a_clip_mode_no_flag, valid_ff[NUM_STAGES-1] && !s6_side_ff.mode, !rsp_sat_in)

endmodule
